>>> rtl/core/lbs_pkg.sv
// Package for the lux-to-brightness block with slew limiting.
// Holds widths, reset values, item kinds, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package lbs_pkg;

  localparam int KNOT_SLOTS      = 4;
  localparam int KNOT_IDX_W      = 2;
  localparam int KNOT_COUNT_DEF  = 4;
  localparam int RAMP_STEP_DEF   = 4;

  localparam int LUX_W           = 16;
  localparam int KLEVEL_W        = 9;
  localparam int LEVEL_W         = 8;

  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Item kinds on the input channel.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_LUX_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_LEVEL_BASE = 3'd4;

  localparam logic [LEVEL_W-1:0]  LEVEL_AT_RESET = 8'd128;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX      = 8'd255;
  localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR    = 8'd3;

  localparam logic [LUX_W-1:0]    KNOT_LUX_RST   [KNOT_SLOTS] =
    '{16'd0, 16'd10, 16'd100, 16'd1000};
  localparam logic [KLEVEL_W-1:0] KNOT_LEVEL_RST [KNOT_SLOTS] =
    '{9'd0, 9'd40, 9'd160, 9'd255};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL_BASE,
    ST_MUL_SLOPE,
    ST_DIV_START,
    ST_DIVIDE,
    ST_DONE
  } lbs_state_t;

endpackage

`default_nettype wire

>>> rtl/core/lbs_in_if.sv
// Input channel of the lux-to-brightness block: a lux sample or a ramp tick.
// Depends on lbs_pkg.
`default_nettype none

interface lbs_in_if
  import lbs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             func;
  logic [LUX_W-1:0] lux;

  modport source (output valid, func, lux, input ready);
  modport sink   (input valid, func, lux, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lbs_out_if.sv
// Result channel of the lux-to-brightness block: levels and status flags.
// Depends on lbs_pkg.
`default_nettype none

interface lbs_out_if
  import lbs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_now;
  logic [LEVEL_W-1:0] level_goal;
  logic               asleep;
  logic               changed;

  modport source (output valid, level_now, level_goal, asleep, changed, input ready);
  modport sink   (input valid, level_now, level_goal, asleep, changed, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lux_to_brightness_slew.sv
// Lux-to-brightness mapping with slew-limited ramping, top level.
// A ramp tick's result is offered in the cycle after acceptance; a lux sample's comes
// after the knot search (one knot per cycle) and, inside a segment, two passes
// through the shared multiplier, a sign check and, for a non-negative sum, a 9-step
// restoring divider. One item at a time: the next is taken the cycle after the
// result leaves. Synchronous active-low reset restores the default knots and sets
// both levels to 128. Depends on lbs_pkg and both interfaces.
`default_nettype none

module lux_to_brightness_slew
  import lbs_pkg::*;
#(
  parameter int KNOT_COUNT = KNOT_COUNT_DEF,
  parameter int RAMP_STEP  = RAMP_STEP_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lbs_in_if.sink                     in_ch,
  lbs_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // The last knot the search may visit, and the ramp step at level width.
  localparam logic [KNOT_IDX_W-1:0] LAST_KNOT = KNOT_IDX_W'(KNOT_COUNT - 1);
  localparam logic [LEVEL_W-1:0]    STEP      = LEVEL_W'(RAMP_STEP);

  localparam int PROD_W = LUX_W + KLEVEL_W + 2;   // signed 17 x signed 10
  localparam int ACC_W  = PROD_W + 1;
  localparam int REM_W  = PROD_W;
  localparam int DSH_W  = LUX_W + KLEVEL_W;

  // Clamp to the level range, force even, and send anything under the floor
  // to zero. The quotient is never negative here; negatives are handled
  // before the divider.
  function automatic logic [LEVEL_W-1:0] shape_level(input logic [KLEVEL_W-1:0] v);
    logic [LEVEL_W-1:0] s;
    begin
      s    = v[KLEVEL_W-1] ? LEVEL_MAX : v[LEVEL_W-1:0];
      s[0] = 1'b0;
      if (s < LEVEL_FLOOR) begin
        s = '0;
      end
      return s;
    end
  endfunction

  // Knot registers, written through the configuration port.
  logic [LUX_W-1:0]    knot_lux_r   [KNOT_SLOTS];
  logic [KLEVEL_W-1:0] knot_level_r [KNOT_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_lux_r   <= KNOT_LUX_RST;
      knot_level_r <= KNOT_LEVEL_RST;
    end else if (cfg_we) begin
      if (cfg_idx < CFG_KNOT_LEVEL_BASE) begin
        knot_lux_r[cfg_idx[KNOT_IDX_W-1:0]] <= cfg_data;
      end else begin
        knot_level_r[cfg_idx[KNOT_IDX_W-1:0]] <= cfg_data[KLEVEL_W-1:0];
      end
    end
  end

  // Sequencer and datapath registers.
  lbs_state_t state_r, state_nxt;

  logic [LEVEL_W-1:0]           cur_r, cur_nxt;
  logic [LEVEL_W-1:0]           tgt_r, tgt_nxt;
  logic                         changed_r, changed_nxt;

  logic [KNOT_IDX_W-1:0]        idx_r, idx_nxt;
  logic [LUX_W-1:0]             lux_r, lux_nxt;
  logic [LUX_W-1:0]             prev_lux_r, prev_lux_nxt;
  logic [KLEVEL_W-1:0]          prev_lvl_r, prev_lvl_nxt;
  logic [LUX_W-1:0]             dl_r, dl_nxt;
  logic [LUX_W-1:0]             dx_r, dx_nxt;
  logic signed [KLEVEL_W:0]     dy_r, dy_nxt;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [DSH_W-1:0]             dsh_r, dsh_nxt;
  logic [KLEVEL_W-1:0]          quo_r, quo_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;

  // The one multiplier is shared: first the base term (level of the knot
  // below times the knot spacing), then the slope term (offset times the
  // level difference). The sum is the interpolation numerator.
  logic signed [LUX_W:0]        mul_a;
  logic signed [KLEVEL_W:0]     mul_b;
  logic signed [PROD_W-1:0]     prod;

  assign mul_a = (state_r == ST_MUL_BASE) ? $signed({1'b0, dl_r}) : $signed({1'b0, dx_r});
  assign mul_b = (state_r == ST_MUL_BASE) ? $signed({1'b0, prev_lvl_r}) : dy_r;
  assign prod  = PROD_W'(mul_a * mul_b);

  // Knot read for the search: one entry per cycle.
  logic [LUX_W-1:0]    knot_lux_sel;
  logic [KLEVEL_W-1:0] knot_lvl_sel;

  assign knot_lux_sel = knot_lux_r[idx_r];
  assign knot_lvl_sel = knot_level_r[idx_r];

  // One divider step: compare against the shifted divisor, subtract on a hit.
  logic [REM_W-1:0]    dsh_ext;
  logic                div_hit;
  logic [KLEVEL_W-1:0] quo_step;

  assign dsh_ext  = REM_W'(dsh_r);
  assign div_hit  = (rem_r >= dsh_ext);
  assign quo_step = {quo_r[KLEVEL_W-2:0], div_hit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= LEVEL_AT_RESET;
      tgt_r     <= LEVEL_AT_RESET;
      changed_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      tgt_r     <= tgt_nxt;
      changed_r <= changed_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lux_r      <= lux_nxt;
    prev_lux_r <= prev_lux_nxt;
    prev_lvl_r <= prev_lvl_nxt;
    dl_r       <= dl_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    tgt_nxt      = tgt_r;
    changed_nxt  = changed_r;
    idx_nxt      = idx_r;
    lux_nxt      = lux_r;
    prev_lux_nxt = prev_lux_r;
    prev_lvl_nxt = prev_lvl_r;
    dl_nxt       = dl_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    dsh_nxt      = dsh_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt   = ST_DONE;
          changed_nxt = 1'b0;
          if (in_ch.func == FUNC_TICK) begin
            // Ramp tick: step toward the target, never past it.
            if (cur_r < tgt_r) begin
              changed_nxt = 1'b1;
              cur_nxt     = ((tgt_r - cur_r) <= STEP) ? tgt_r : cur_r + STEP;
            end else if (cur_r > tgt_r) begin
              changed_nxt = 1'b1;
              cur_nxt     = ((cur_r - tgt_r) <= STEP) ? tgt_r : cur_r - STEP;
            end
          end else begin
            lux_nxt   = in_ch.lux;
            idx_nxt   = '0;
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (lux_r < knot_lux_sel) begin
          if (idx_r == '0) begin
            // Below the first knot the target is the first knot's level.
            tgt_nxt   = shape_level(knot_lvl_sel);
            state_nxt = ST_DONE;
          end else begin
            dl_nxt    = knot_lux_sel - prev_lux_r;
            dx_nxt    = lux_r - prev_lux_r;
            dy_nxt    = $signed({1'b0, knot_lvl_sel}) - $signed({1'b0, prev_lvl_r});
            state_nxt = ST_MUL_BASE;
          end
        end else if (idx_r == LAST_KNOT) begin
          // At or beyond the last knot the target stays as it is.
          state_nxt = ST_DONE;
        end else begin
          // Keep the knot just passed; it becomes the lower end of the segment.
          prev_lux_nxt = knot_lux_sel;
          prev_lvl_nxt = knot_lvl_sel;
          idx_nxt      = idx_r + 1'b1;
        end
      end

      ST_MUL_BASE: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = ST_MUL_SLOPE;
      end

      ST_MUL_SLOPE: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = ST_DIV_START;
      end

      ST_DIV_START: begin
        if (acc_r < 0) begin
          // A falling segment that goes negative saturates to zero.
          tgt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          // The quotient is bounded by the larger knot level, so nine
          // quotient bits cover it.
          rem_nxt   = acc_r[REM_W-1:0];
          dsh_nxt   = {dl_r, {KLEVEL_W-1{1'b0}}, 1'b0} >> 1;
          quo_nxt   = '0;
          cnt_nxt   = 4'(KLEVEL_W - 1);
          state_nxt = ST_DIVIDE;
        end
      end

      ST_DIVIDE: begin
        if (div_hit) begin
          rem_nxt = rem_r - dsh_ext;
        end
        quo_nxt = quo_step;
        dsh_nxt = dsh_r >> 1;
        if (cnt_r == '0) begin
          tgt_nxt   = shape_level(quo_step);
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      ST_DONE: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result fields come straight from the level registers, which hold
  // still while the item waits on the result channel.
  assign out_ch.level_now  = cur_r;
  assign out_ch.level_goal = tgt_r;
  assign out_ch.asleep     = (tgt_r == '0);
  assign out_ch.changed    = changed_r;

endmodule

`default_nettype wire
